// ===== rtl/core/lvr_pkg.sv =====
// Shared types, widths and codes for the low-variance resampler core.
// Used by lvr_ctrl, lvr_datapath and low_variance_resampler_core.
package lvr_pkg;

  localparam int unsigned MaxParticles = 512;
  localparam int unsigned WeightBits   = 32;
  localparam int unsigned OffsetBits   = 16;

  localparam int unsigned IdxBits    = $clog2(MaxParticles);
  localparam int unsigned CntBits    = IdxBits + 1;
  localparam int unsigned TotalBits  = WeightBits + IdxBits;
  localparam int unsigned PointBits  = OffsetBits + CntBits;
  localparam int unsigned SplitBits  = (TotalBits + 1) / 2;
  localparam int unsigned HiBits     = TotalBits - SplitBits;
  localparam int unsigned LoProdBits = PointBits + SplitBits;
  localparam int unsigned HiProdBits = PointBits + HiBits;
  localparam int unsigned LhsBits    = PointBits + TotalBits;
  localparam int unsigned RhsBits    = TotalBits + CntBits;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_DRAW  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_DONE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_CMP,
    S_RHS
  } state_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic [WeightBits-1:0] weight;
    logic [OffsetBits-1:0] offset;
  } item_t;

  typedef struct packed {
    logic [IdxBits-1:0] particle_index;
    status_e            status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic begin_set;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic lhs_sum;
    logic rhs_mul;
    logic advance;
    logic out_empty;
    logic out_done;
    logic out_uniform;
    logic out_pick;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic draws_done;
    logic total_zero;
    logic beyond;
    logic at_end;
  } stat_t;

endpackage

// ===== rtl/core/lvr_ctrl.sv =====
// Controller for the resampler: decodes transactions and sequences the draw loop.
// Depends on lvr_pkg for state, command and status types.
module lvr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    kind_i,
  input  lvr_pkg::stat_t stat_i,
  output logic          busy_o,
  output lvr_pkg::cmd_t cmd_o
);

  lvr_pkg::state_e state_q, state_d;
  logic accept;
  logic draw_go;
  logic draw_short;

  assign accept     = start_i && (state_q == lvr_pkg::S_IDLE);
  assign draw_go    = accept && (kind_i == lvr_pkg::KIND_DRAW);
  assign draw_short = stat_i.count_zero || stat_i.draws_done || stat_i.total_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lvr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lvr_pkg::S_IDLE: begin
        if (draw_go && !draw_short) begin
          state_d = lvr_pkg::S_MUL_LO;
        end
      end
      lvr_pkg::S_MUL_LO: state_d = lvr_pkg::S_MUL_HI;
      lvr_pkg::S_MUL_HI: state_d = lvr_pkg::S_SUM;
      lvr_pkg::S_SUM:    state_d = lvr_pkg::S_CMP;
      lvr_pkg::S_CMP: begin
        if (stat_i.beyond && !stat_i.at_end) begin
          state_d = lvr_pkg::S_RHS;
        end else begin
          state_d = lvr_pkg::S_IDLE;
        end
      end
      lvr_pkg::S_RHS:    state_d = lvr_pkg::S_CMP;
      default:           state_d = lvr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != lvr_pkg::S_IDLE);
    case (state_q)
      lvr_pkg::S_IDLE: begin
        cmd_o.begin_set   = accept && (kind_i == lvr_pkg::KIND_BEGIN);
        cmd_o.load        = accept && (kind_i == lvr_pkg::KIND_LOAD);
        cmd_o.out_empty   = draw_go && stat_i.count_zero;
        cmd_o.out_done    = draw_go && !stat_i.count_zero && stat_i.draws_done;
        cmd_o.out_uniform = draw_go && !stat_i.count_zero && !stat_i.draws_done
                            && stat_i.total_zero;
      end
      lvr_pkg::S_MUL_LO: begin
        cmd_o.mul_lo  = 1'b1;
        cmd_o.rhs_mul = 1'b1;
      end
      lvr_pkg::S_MUL_HI: cmd_o.mul_hi  = 1'b1;
      lvr_pkg::S_SUM:    cmd_o.lhs_sum = 1'b1;
      lvr_pkg::S_CMP: begin
        cmd_o.advance  = stat_i.beyond && !stat_i.at_end;
        cmd_o.out_pick = !(stat_i.beyond && !stat_i.at_end);
      end
      lvr_pkg::S_RHS:    cmd_o.rhs_mul = 1'b1;
      default:           cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/core/lvr_datapath.sv =====
// Datapath for the resampler: weight memory, sums, split multiplier, compare, result register.
// Depends on lvr_pkg for widths, payload and command/status types.
module lvr_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lvr_pkg::item_t   item_i,
  input  lvr_pkg::cmd_t    cmd_i,
  output lvr_pkg::stat_t   stat_o,
  output logic             result_valid_o,
  output lvr_pkg::result_t result_o
);

  logic [lvr_pkg::WeightBits-1:0] mem_q [lvr_pkg::MaxParticles];
  logic [lvr_pkg::WeightBits-1:0] rd_q;

  logic [lvr_pkg::CntBits-1:0]    count_q, count_d;
  logic [lvr_pkg::CntBits-1:0]    draw_q, draw_d;
  logic [lvr_pkg::IdxBits-1:0]    cursor_q, cursor_d;
  logic [lvr_pkg::TotalBits-1:0]  total_q, total_d;
  logic [lvr_pkg::TotalBits-1:0]  sum_q, sum_d;
  logic [lvr_pkg::OffsetBits-1:0] frac_q, frac_d;

  logic [lvr_pkg::LoProdBits-1:0] lhs_lo_q;
  logic [lvr_pkg::HiProdBits-1:0] lhs_hi_q;
  logic [lvr_pkg::LhsBits-1:0]    lhs_q;
  logic [lvr_pkg::RhsBits-1:0]    rhs_q;

  logic                           valid_q, valid_d;
  lvr_pkg::result_t               result_q, result_d;

  logic [lvr_pkg::PointBits-1:0]  point;
  logic [lvr_pkg::IdxBits-1:0]    next_addr;
  logic [lvr_pkg::CntBits-1:0]    cursor_ext;
  logic [lvr_pkg::CntBits-1:0]    draw_inc;
  logic                           full;
  logic                           is_last;

  // Sample point (r + m) scaled by 2^OffsetBits: r is below 2^OffsetBits, so concatenate.
  assign point      = {draw_q, frac_q};
  assign next_addr  = cursor_q + lvr_pkg::IdxBits'(1);
  assign cursor_ext = {1'b0, cursor_q};
  assign draw_inc   = draw_q + lvr_pkg::CntBits'(1);
  assign full       = (count_q == lvr_pkg::CntBits'(lvr_pkg::MaxParticles));
  assign is_last    = (draw_inc == count_q);

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.draws_done = (draw_q >= count_q);
  assign stat_o.total_zero = (total_q == '0);
  assign stat_o.at_end     = ((cursor_ext + lvr_pkg::CntBits'(1)) >= count_q);
  assign stat_o.beyond     = (lhs_q > {rhs_q, {lvr_pkg::OffsetBits{1'b0}}});

  // Weight memory: one write port for loads, one registered read port ahead of the cursor.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[count_q[lvr_pkg::IdxBits-1:0]] <= item_i.weight;
    end
    rd_q <= mem_q[next_addr];
  end

  always_comb begin
    count_d  = count_q;
    draw_d   = draw_q;
    cursor_d = cursor_q;
    total_d  = total_q;
    sum_d    = sum_q;
    frac_d   = frac_q;
    if (cmd_i.begin_set) begin
      count_d  = '0;
      draw_d   = '0;
      cursor_d = '0;
      total_d  = '0;
      sum_d    = '0;
      frac_d   = item_i.offset;
    end
    if (cmd_i.load && !full) begin
      total_d = total_q + lvr_pkg::TotalBits'(item_i.weight);
      count_d = count_q + lvr_pkg::CntBits'(1);
      // The cursor stands on the particle being loaded: fold it into the running sum.
      if (count_q == cursor_ext) begin
        sum_d = sum_q + lvr_pkg::TotalBits'(item_i.weight);
      end
    end
    if (cmd_i.advance) begin
      cursor_d = next_addr;
      sum_d    = sum_q + lvr_pkg::TotalBits'(rd_q);
    end
    if (cmd_i.out_uniform || cmd_i.out_pick) begin
      draw_d = draw_inc;
    end
  end

  always_comb begin
    valid_d  = cmd_i.out_empty || cmd_i.out_done || cmd_i.out_uniform || cmd_i.out_pick;
    result_d = result_q;
    if (cmd_i.out_empty) begin
      result_d.particle_index = '0;
      result_d.status         = lvr_pkg::STATUS_EMPTY;
      result_d.last           = 1'b0;
    end else if (cmd_i.out_done) begin
      result_d.particle_index = '0;
      result_d.status         = lvr_pkg::STATUS_DONE;
      result_d.last           = 1'b0;
    end else if (cmd_i.out_uniform) begin
      result_d.particle_index = draw_q[lvr_pkg::IdxBits-1:0];
      result_d.status         = lvr_pkg::STATUS_OK;
      result_d.last           = is_last;
    end else if (cmd_i.out_pick) begin
      result_d.particle_index = cursor_q;
      result_d.status         = lvr_pkg::STATUS_OK;
      result_d.last           = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      draw_q   <= '0;
      cursor_q <= '0;
      total_q  <= '0;
      sum_q    <= '0;
      frac_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      draw_q   <= draw_d;
      cursor_q <= cursor_d;
      total_q  <= total_d;
      sum_q    <= sum_d;
      frac_q   <= frac_d;
      valid_q  <= valid_d;
    end
  end

  // Point times total in two halves of the total, then one wide add.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      lhs_lo_q <= lvr_pkg::LoProdBits'(point)
                * lvr_pkg::LoProdBits'(total_q[lvr_pkg::SplitBits-1:0]);
    end
    if (cmd_i.mul_hi) begin
      lhs_hi_q <= lvr_pkg::HiProdBits'(point)
                * lvr_pkg::HiProdBits'(total_q[lvr_pkg::TotalBits-1:lvr_pkg::SplitBits]);
    end
    if (cmd_i.lhs_sum) begin
      lhs_q <= (lvr_pkg::LhsBits'(lhs_hi_q) << lvr_pkg::SplitBits)
             + lvr_pkg::LhsBits'(lhs_lo_q);
    end
    if (cmd_i.rhs_mul) begin
      rhs_q <= lvr_pkg::RhsBits'(sum_q) * lvr_pkg::RhsBits'(count_q);
    end
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

// ===== rtl/core/low_variance_resampler_core.sv =====
// Low-variance (systematic) resampler core for a particle filter.
// Channels: command input (start/busy, item_i) and a one-cycle result strobe.
// A begin transaction clears the particle set and latches the start fraction;
// load transactions append weights; each draw transaction returns one index.
// Begin and load complete at the accepting edge and never raise busy.
// A draw with no particles, with all draws used, or with a zero total weight
// returns its result in the next cycle without raising busy.
// Any other draw keeps busy high through the point-times-total product, split
// into low and high halves, the wide add, and the cursor loop: one weight
// memory read and one compare per cursor step. Its result strobe comes in
// the cycle busy falls.
// Over a whole pass the cursor moves at most once per particle.
// Results are held for exactly one cycle; the receiver cannot stall them.
// Reset clears the particle set and all counters; the weight memory keeps
// its contents, and only words below the loaded count are used.
// Depends on lvr_pkg, lvr_ctrl and lvr_datapath.
module low_variance_resampler_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lvr_pkg::item_t   item_i,
  output logic             result_valid_o,
  output lvr_pkg::result_t result_o
);

  lvr_pkg::cmd_t  cmd;
  lvr_pkg::stat_t stat;

  lvr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (item_i.kind),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  lvr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // A long draw ends with its result in the same cycle busy drops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  // Begin and load transactions produce no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.kind != lvr_pkg::KIND_DRAW)) |=> !result_valid_o)
    else $error("result after a non-draw transaction");

  // Never step the cursor past the last loaded particle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.advance |-> !stat.at_end)
    else $error("cursor advanced past the last particle");

  // At most one result source per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.out_empty, cmd.out_done, cmd.out_uniform, cmd.out_pick}))
    else $error("conflicting result commands");

endmodule
